>>> hw/rtl/first_fit_unit_allocator_assert.svh
// assertion macros shared by the checker of first_fit_unit_allocator
// no dependencies; the clock and the active-low reset are passed in
`ifndef FIRST_FIT_UNIT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_ASSERT_SVH

// consequent checked in the same cycle
`define FFUA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FFUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ffua_pkg.sv
// shared types and constants of the first-fit unit allocator
// no dependencies
package ffua_pkg;

    localparam int POOL_UNITS_DEF = 128;
    localparam int SIZE_W         = 8;
    localparam int START_W        = 7;
    localparam int LEN_W          = 8;

    typedef enum logic [0:0] {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [SIZE_W-1:0]  request_size;
        logic [START_W-1:0] release_start;
    } t_in;

    typedef struct packed {
        logic [START_W-1:0] granted_start;
        logic               success;
    } t_out;

endpackage

>>> hw/rtl/ffua_run_unit.sv
// free-run counter and compare unit, used one bitmap sample per cycle while i_en is high
// depends on ffua_pkg
module ffua_run_unit
    import ffua_pkg::*;
#(
    parameter int POOL_UNITS = POOL_UNITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic                          i_en,
    input  logic                          i_busy,
    input  logic [LEN_W-1:0]              i_want,
    input  logic [$clog2(POOL_UNITS)-1:0] i_addr,
    output logic                          o_hit,
    output logic [$clog2(POOL_UNITS)-1:0] o_start
);

    localparam int AW  = $clog2(POOL_UNITS);
    localparam int CW  = $clog2(POOL_UNITS + 1);
    localparam int SW  = (CW > LEN_W) ? CW : LEN_W;

    logic [LEN_W-1:0] r_run;
    logic [LEN_W-1:0] n_inc;
    logic [SW-1:0]    start_wide;

    assign n_inc = r_run + LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_run <= '0;
        end else if (i_en) begin
            r_run <= i_busy ? '0 : n_inc;
        end
    end

    // run ends at i_addr, so it began want-1 units earlier
    assign start_wide = SW'(i_addr) + SW'(1) - SW'(i_want);
    assign o_start    = AW'(start_wide);
    assign o_hit      = i_en && !i_busy && (n_inc == i_want);

endmodule

>>> hw/rtl/first_fit_unit_allocator.sv
// first-fit allocator: sequencer, busy bitmap and run-length table
// depends on ffua_pkg and ffua_run_unit
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------
//  input   | i_in_valid  | o_in_ready  | i_in_data  (t_in)
//  output  | o_out_valid | i_out_ready | o_out_data (t_out)
//
// request: accept, bitmap scan (one unit a cycle through the single bitmap read port),
//   marking of request_size units, result
// release: accept, table read, freeing up to the run length of units (or to the top of the pool), result
// bad size or bad start: accept, then result
// after reset a clearing pass over all POOL_UNITS units runs with o_in_ready low
// a waiting result does not block the next input beat; the block holds in its
//   result state only when the output register is still full
module first_fit_unit_allocator
    import ffua_pkg::*;
#(
    parameter int POOL_UNITS = POOL_UNITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(POOL_UNITS);
    localparam int CW = $clog2(POOL_UNITS + 1);
    localparam int SW = (CW > LEN_W) ? CW : LEN_W;
    localparam logic [AW-1:0] LAST = AW'(POOL_UNITS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_REL_LEN,
        S_REL_FREE,
        S_RESP
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_wr_addr;
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_start;
    logic [AW-1:0]    r_chk_addr;
    logic             r_chk_vld;
    logic             r_busy_q;
    logic [LEN_W-1:0] r_len_q;
    logic [LEN_W-1:0] r_left;
    logic [LEN_W-1:0] r_want;
    t_out             r_res;
    logic             r_out_valid;
    t_out             r_out_data;

    logic             r_busy_mem [POOL_UNITS];
    logic [LEN_W-1:0] r_len_mem  [POOL_UNITS];

    logic             in_fire;
    logic             out_fire;
    logic             res_load;
    logic             size_ok;
    logic             rel_ok;
    logic [AW-1:0]    rel_addr;
    logic             busy_we;
    logic             busy_wd;
    logic             len_we;
    logic [AW-1:0]    len_wa;
    logic [LEN_W-1:0] len_wd;
    logic             run_hit;
    logic [AW-1:0]    run_start;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign res_load    = (r_state == S_RESP) && (!r_out_valid || i_out_ready);

    assign size_ok  = (i_in_data.request_size != '0) &&
                      (SW'(i_in_data.request_size) <= SW'(POOL_UNITS));
    assign rel_ok   = SW'(i_in_data.release_start) < SW'(POOL_UNITS);
    assign rel_addr = AW'(i_in_data.release_start);

    ffua_run_unit #(
        .POOL_UNITS (POOL_UNITS)
    ) u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (r_state != S_SCAN),
        .i_en    (r_chk_vld && (r_state == S_SCAN)),
        .i_busy  (r_busy_q),
        .i_want  (r_want),
        .i_addr  (r_chk_addr),
        .o_hit   (run_hit),
        .o_start (run_start)
    );

    // write port selection for both memories
    always_comb begin
        busy_we = 1'b0;
        busy_wd = 1'b0;
        len_we  = 1'b0;
        len_wa  = r_wr_addr;
        len_wd  = '0;
        unique case (r_state)
            S_CLEAR: begin
                busy_we = 1'b1;
                len_we  = 1'b1;
            end
            S_SCAN: begin
                if (run_hit) begin
                    len_we = 1'b1;
                    len_wa = run_start;
                    len_wd = r_want;
                end
            end
            S_MARK: begin
                busy_we = 1'b1;
                busy_wd = 1'b1;
            end
            S_REL_LEN: begin
                if (r_len_q != '0) begin
                    len_we = 1'b1;
                    len_wa = r_start;
                end
            end
            S_REL_FREE: begin
                busy_we = 1'b1;
            end
            S_IDLE, S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (busy_we) begin
            r_busy_mem[r_wr_addr] <= busy_wd;
        end
        r_busy_q <= r_busy_mem[r_rd_addr];
    end

    // table read is only used after a release with an in-range start
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_mem[len_wa] <= len_wd;
        end
        r_len_q <= r_len_mem[rel_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wr_addr   <= '0;
            r_rd_addr   <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chk_addr  <= r_rd_addr;
            r_chk_vld   <= (r_state == S_SCAN);
            // a new result loads, a stalled one stays, a taken one clears
            r_out_valid <= res_load || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_CLEAR: begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                    if (r_wr_addr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_want    <= i_in_data.request_size;
                        r_start   <= rel_addr;
                        r_rd_addr <= '0;
                        r_res     <= '{granted_start: '0, success: 1'b0};
                        if (i_in_data.operation == OP_REQUEST) begin
                            r_state <= size_ok ? S_SCAN : S_RESP;
                        end else begin
                            r_state <= rel_ok ? S_REL_LEN : S_RESP;
                        end
                    end
                end
                S_SCAN: begin
                    // read issue runs one unit ahead of the sample being checked
                    if (r_rd_addr != LAST) begin
                        r_rd_addr <= r_rd_addr + AW'(1);
                    end
                    if (run_hit) begin
                        r_start   <= run_start;
                        r_wr_addr <= run_start;
                        r_left    <= r_want;
                        r_state   <= S_MARK;
                    end else if (r_chk_vld && (r_chk_addr == LAST)) begin
                        r_state <= S_RESP;
                    end
                end
                S_MARK: begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                    r_left    <= r_left - LEN_W'(1);
                    if (r_left == LEN_W'(1)) begin
                        r_res   <= '{granted_start: START_W'(r_start), success: 1'b1};
                        r_state <= S_RESP;
                    end
                end
                S_REL_LEN: begin
                    if (r_len_q == '0) begin
                        r_state <= S_RESP;
                    end else begin
                        r_left    <= r_len_q;
                        r_wr_addr <= r_start;
                        r_state   <= S_REL_FREE;
                    end
                end
                S_REL_FREE: begin
                    r_wr_addr <= r_wr_addr + AW'(1);
                    r_left    <= r_left - LEN_W'(1);
                    // stop at the run end or at the top of the pool
                    if ((r_left == LEN_W'(1)) || (r_wr_addr == LAST)) begin
                        r_res   <= '{granted_start: '0, success: 1'b1};
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (res_load) begin
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/ffua_checker.sv
// port-level checks of first_fit_unit_allocator, bound to the top level
// depends on ffua_pkg and first_fit_unit_allocator_assert.svh
`include "first_fit_unit_allocator_assert.svh"

module ffua_checker
    import ffua_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a failed beat never reports a start unit
    `FFUA_ASSERT_NOW(a_fail_no_start, i_clk, i_rst_n,
        o_out_valid && !o_out_data.success, o_out_data.granted_start == '0,
        "failed result carries a start unit")

    // one item at a time: input closes right after a beat is taken
    `FFUA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready,
        "input still open after accepting a beat")

    // clearing pass keeps input closed in the first cycle out of reset
    `FFUA_ASSERT_NOW(a_clear_after_reset, i_clk, i_rst_n,
        $past(!i_rst_n), !o_in_ready,
        "input open before the clearing pass")

    `FFUA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data),
        "stalled result dropped or changed")

endmodule

bind first_fit_unit_allocator ffua_checker u_ffua_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/tb_first_fit_unit_allocator.sv
// self-checking testbench for first_fit_unit_allocator: directed and random request/release beats
// keeps its own busy map and length table to predict every result beat
// depends on ffua_pkg and the first_fit_unit_allocator rtl
module tb_first_fit_unit_allocator;
    import ffua_pkg::*;

    localparam int POOL          = POOL_UNITS_DEF;
    localparam int PHASE_ITEMS   = 413;
    localparam int DRAIN_CYCLES  = 300;
    localparam int LIMIT_CYCLES  = 4_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // predicted pool state, updated as input beats are accepted
    bit         unit_taken [POOL];
    logic [7:0] run_len    [POOL];

    t_in  pending_beats [$];
    t_out expected_results [$];
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    first_fit_unit_allocator #(.POOL_UNITS(POOL)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_in make_item(t_op op, int size, int start);
        t_in item;
        item.operation     = op;
        item.request_size  = SIZE_W'(size);
        item.release_start = START_W'(start);
        return item;
    endfunction

    // first-fit search, marking and release on the predicted pool
    function automatic t_out allocate_or_free(t_in item);
        t_out res;
        int   run;
        int   at;
        int   u;
        int   len;
        int   start;
        bit   found;
        res   = '0;
        found = 1'b0;
        run   = 0;
        at    = 0;
        start = int'(item.release_start);
        if (item.operation == OP_REQUEST) begin
            if (item.request_size != 0 && int'(item.request_size) <= POOL) begin
                for (u = 0; u < POOL && !found; u++) begin
                    if (unit_taken[u]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(item.request_size)) begin
                            found = 1'b1;
                            at    = u + 1 - run;
                        end
                    end
                end
                if (found) begin
                    for (u = at; u < at + int'(item.request_size); u++) begin
                        unit_taken[u] = 1'b1;
                    end
                    run_len[at]       = item.request_size;
                    res.granted_start = START_W'(at);
                    res.success       = 1'b1;
                end
            end
        end else if (start < POOL && run_len[start] != 0) begin
            len = int'(run_len[start]);
            for (u = start; u < start + len && u < POOL; u++) begin
                unit_taken[u] = 1'b0;
            end
            run_len[start] = '0;
            res.success    = 1'b1;
        end
        return res;
    endfunction

    // driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk) begin : driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(allocate_or_free(in_data));
            end
            if (!in_valid || in_ready) begin
                if (pending_beats.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat %p", $time, out_data);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.granted_start !== want.granted_start) begin
                        $display("%0t: granted_start expected %0d got %0d",
                                 $time, want.granted_start, out_data.granted_start);
                        error_count++;
                    end
                    if (out_data.success !== want.success) begin
                        $display("%0t: success expected %0b got %0b",
                                 $time, want.success, out_data.success);
                        error_count++;
                    end
                end
            end
            out_ready <= int'($urandom_range(99)) >= stall_pct;
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_first_fit_unit_allocator: done, errors");
        $finish;
    end

    initial begin : stimulus
        int starts [$];
        int phase;
        int sent;
        int chunk;
        int roll;
        int pick;
        int size;
        int u;

        for (u = 0; u < POOL; u++) begin
            unit_taken[u] = 1'b0;
            run_len[u]    = '0;
        end

        // directed: bad sizes, full pool, no fit, bad releases, end of pool, first fit
        pending_beats.push_back(make_item(OP_REQUEST, 0, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 255, 127));
        pending_beats.push_back(make_item(OP_REQUEST, 129, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 128, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 1, 0));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 5));
        pending_beats.push_back(make_item(OP_RELEASE, 255, 0));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 0));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 127));
        pending_beats.push_back(make_item(OP_REQUEST, 127, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 1, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 1, 0));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 127));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 3, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 5, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 2, 0));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 3));
        pending_beats.push_back(make_item(OP_REQUEST, 6, 0));
        pending_beats.push_back(make_item(OP_REQUEST, 4, 0));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 64));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 42));
        pending_beats.push_back(make_item(OP_RELEASE, 0, 85));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // wait until every queued beat is accepted so the table is current
                do @(negedge clk); while (pending_beats.size() != 0 || in_valid);
                starts.delete();
                for (u = 0; u < POOL; u++) begin
                    if (run_len[u] != 0) starts.push_back(u);
                end
                chunk = $urandom_range(1, 12);
                repeat (chunk) begin
                    roll = $urandom_range(99);
                    if (roll < 55) begin
                        roll = $urandom_range(99);
                        if (roll < 70)      size = $urandom_range(1, 8);
                        else if (roll < 90) size = $urandom_range(9, 32);
                        else if (roll < 97) size = $urandom_range(33, 128);
                        else if (roll < 98) size = 0;
                        else                size = $urandom_range(129, 255);
                        pending_beats.push_back(
                            make_item(OP_REQUEST, size, $urandom_range(127)));
                    end else if (roll < 95 && starts.size() != 0) begin
                        pick = $urandom_range(starts.size() - 1);
                        pending_beats.push_back(
                            make_item(OP_RELEASE, $urandom_range(255), starts[pick]));
                        starts.delete(pick);
                    end else begin
                        pending_beats.push_back(
                            make_item(OP_RELEASE, $urandom_range(255), $urandom_range(127)));
                    end
                    sent++;
                end
            end
        end

        do @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d result beats never arrived", $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_first_fit_unit_allocator: done, clean");
        end else begin
            $display("tb_first_fit_unit_allocator: done, errors");
        end
        $finish;
    end

endmodule

>>> first_fit_unit_allocator.f
+incdir+hw/rtl
hw/rtl/ffua_pkg.sv
hw/rtl/ffua_run_unit.sv
hw/rtl/first_fit_unit_allocator.sv
hw/rtl/ffua_checker.sv
tb/tb_first_fit_unit_allocator.sv
